FILE: sv/dlpd_pkg.sv
// ----------------------------------------------------------------------------
// dlpd_pkg
// shared types and constants of the dual-length packet deframer
// ----------------------------------------------------------------------------
package dlpd_pkg;

   localparam int NUM_PORTS = 2;
   localparam int PORT_W    = 1;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LEN = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LEN  = 4'd1;

   localparam logic [BYTE_W-1:0] SHORT_LEN_RESET = 8'd14;
   localparam logic [BYTE_W-1:0] LONG_LEN_RESET  = 8'd124;

   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SHORT = 8'h73;
   localparam logic [BYTE_W-1:0] CH_LONG  = 8'h62;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_ARMED   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_STORED = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_ABORT  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [PORT_W-1:0]   port;
      logic [BYTE_W-1:0]   data;
      logic [BYTE_W-1:0]   index;
      logic                long_packet;
   } result_type;

endpackage

FILE: sv/dlpd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// dlpd_frame_ctrl
// per-port framing state and the decision for one received byte
// ----------------------------------------------------------------------------
module dlpd_frame_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [dlpd_pkg::PORT_W-1:0] port,
   input  logic [dlpd_pkg::BYTE_W-1:0] byte_in,
   input  logic [dlpd_pkg::BYTE_W-1:0] short_len,
   input  logic [dlpd_pkg::BYTE_W-1:0] long_len,
   output logic                       has_result,
   output dlpd_pkg::result_type       result
);
   import dlpd_pkg::*;

   mode_type          mode_ff [NUM_PORTS];
   mode_type          mode_in [NUM_PORTS];
   logic              sel_ff  [NUM_PORTS];
   logic              sel_in  [NUM_PORTS];
   logic [BYTE_W-1:0] fill_ff [NUM_PORTS];
   logic [BYTE_W-1:0] fill_in [NUM_PORTS];

   mode_type          mode_new;
   logic              sel_new;
   logic [BYTE_W-1:0] fill_new;
   logic [BYTE_W-1:0] len;
   logic [BYTE_W-1:0] limit;
   logic              len_zero;
   logic              port_ok;

   always_comb begin
      port_ok    = (int'(port) < NUM_PORTS);
      mode_new   = mode_ff[port];
      sel_new    = sel_ff[port];
      fill_new   = fill_ff[port];
      has_result = 1'b0;
      result     = '{kind: KIND_STORED, port: port, data: byte_in,
                     index: fill_ff[port], long_packet: sel_ff[port]};

      unique case (mode_new)
         MODE_ARMED: begin
            if (byte_in == CH_SHORT) begin
               sel_new  = 1'b0;
               mode_new = MODE_COLLECT;
            end else if (byte_in == CH_LONG) begin
               sel_new  = 1'b1;
               mode_new = MODE_COLLECT;
            end else begin
               mode_new = MODE_IDLE;
            end
         end
         MODE_IDLE, MODE_COLLECT: ;
         default: mode_new = MODE_IDLE;
      endcase

      len      = sel_new ? long_len : short_len;
      len_zero = (len == '0);
      limit    = len - 8'd1;
      result.long_packet = sel_new;

      if (mode_new == MODE_COLLECT) begin
         if (byte_in == CH_NL) begin
            has_result  = 1'b1;
            result.kind = (!len_zero && fill_new == limit) ? KIND_COMMIT : KIND_ABORT;
            fill_new    = '0;
            mode_new    = MODE_IDLE;
         end else if (byte_in != CH_CR && byte_in != CH_TAB) begin
            if (!len_zero && fill_new < limit) begin
               has_result = 1'b1;
               fill_new   = fill_new + 8'd1;
            end
         end
      end

      if (byte_in == CH_TAB) begin
         mode_new = MODE_ARMED;
      end

      if (!port_ok) begin
         has_result = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PORTS; i++) begin
         mode_in[i] = mode_ff[i];
         sel_in[i]  = sel_ff[i];
         fill_in[i] = fill_ff[i];
         if (fire && port_ok && int'(port) == i) begin
            mode_in[i] = mode_new;
            sel_in[i]  = sel_new;
            fill_in[i] = fill_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
         if (reset) begin
            mode_ff[i] <= MODE_IDLE;
            sel_ff[i]  <= 1'b0;
            fill_ff[i] <= '0;
         end else begin
            mode_ff[i] <= mode_in[i];
            sel_ff[i]  <= sel_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   a_stored_is_data: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && result.kind == KIND_STORED |->
         byte_in != CH_NL && byte_in != CH_CR && byte_in != CH_TAB)
      else $error("control byte stored as data");

   a_end_is_newline: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && result.kind != KIND_STORED |->
         result.data == CH_NL && byte_in == CH_NL)
      else $error("packet end without newline");

   a_fill_advance: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && result.kind == KIND_STORED |=>
         fill_ff[$past(port)] == $past(result.index) + 8'd1)
      else $error("fill index did not advance after store");

   a_end_clears_fill: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && result.kind != KIND_STORED |=>
         fill_ff[$past(port)] == '0 && mode_ff[$past(port)] == MODE_IDLE)
      else $error("port not cleared after packet end");

endmodule

FILE: sv/dlpd_out_stage.sv
// ----------------------------------------------------------------------------
// dlpd_out_stage
// result register toward the response stream
// ----------------------------------------------------------------------------
module dlpd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dlpd_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // data_byte, byte_index
   output logic [7:0]           rsp_tuser    // result_kind[1:0], out_port, long_packet
);
   import dlpd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.index, res_ff.data};
   assign rsp_tuser  = {4'd0, res_ff.long_packet, res_ff.port, res_ff.kind};

endmodule

FILE: sv/dual_length_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// dual_length_packet_deframer_core
// splits tagged receive bytes into short or long packets per port
// ----------------------------------------------------------------------------
// req stream: one received byte in tdata, its receive port in tuser.
// rsp stream: zero or one result per byte: a stored byte with its index,
// a packet commit or a packet abort, with port and long/short flag.
// csr channel: index 0 short packet length, index 1 long packet length;
// it must be written only while the block is idle, which the block itself
// does not enforce; csr_ready is always high. A byte is held in an
// input register, then the per-port update runs and its result lands in
// the output register, which drives rsp_tvalid. One byte per cycle is
// sustained while results are taken; the per-port state update is combinational.
// Reset (synchronous, active high) puts every port idle with index 0 and
// restores lengths 14 and 124. When the receiver stalls, the output
// register holds its result; bytes that yield no result still drain,
// and req_tready drops once a byte that needs the busy output waits.
// ----------------------------------------------------------------------------
module dual_length_packet_deframer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // byte_in
   input  logic [0:0]                    req_tuser,   // port
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // data_byte, byte_index
   output logic [7:0]                    rsp_tuser,   // result_kind[1:0], out_port, long_packet
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dlpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import dlpd_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [PORT_W-1:0] in_port_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [BYTE_W-1:0] short_len_ff;
   logic [BYTE_W-1:0] long_len_ff;
   logic              accept;
   logic              advance;
   logic              has_result;
   logic              out_free;
   result_type        result;

   assign csr_ready   = 1'b1;
   assign advance     = in_valid_ff && (out_free || !has_result);
   assign req_tready  = !in_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         short_len_ff <= SHORT_LEN_RESET;
         long_len_ff  <= LONG_LEN_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SHORT_LEN) begin
               short_len_ff <= csr_data;
            end else if (csr_index == CSR_LONG_LEN) begin
               long_len_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_port_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   dlpd_frame_ctrl u_frame_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .port       (in_port_ff),
      .byte_in    (in_byte_ff),
      .short_len  (short_len_ff),
      .long_len   (long_len_ff),
      .has_result (has_result),
      .result     (result)
   );

   dlpd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
